>>> rtl/core/kabf_pkg.sv
// shared types and constants of the angle and bias kalman filter
`default_nettype none
package kabf_pkg;

  localparam int unsigned DW = 32;
  localparam int unsigned FB = 16;

  typedef struct packed {
    logic signed [DW-1:0] measured_value;
    logic signed [DW-1:0] measured_rate;
    logic [DW-1:0]        elapsed_time;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] estimate;
    logic signed [DW-1:0] bias_estimate;
    logic signed [DW-1:0] corrected_rate;
    logic signed [DW-1:0] step_velocity;
    logic                 skipped;
  } out_item_t;

  // register indexes
  localparam logic [2:0] REG_INIT = 3'd0;
  localparam logic [2:0] REG_LIFE = 3'd1;
  localparam logic [2:0] REG_QV   = 3'd2;
  localparam logic [2:0] REG_QB   = 3'd3;
  localparam logic [2:0] REG_R    = 3'd4;

  // shared unit operations
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;

  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  function automatic logic signed [DW-1:0] sat_u(input logic [DW-1:0] v);
    sat_u = v[DW-1] ? SMAX : v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/kalman_angle_bias_filter_core.sv
// top level of the two-state angle and bias kalman filter
// channels: in_ (measured value, rate, elapsed time) and out_ (one result item
// per input item), both valid/stall; cfg_ is an apb-style register port.
// registers at 4*i: initial_estimate, lifespan, process noise value and bias,
// measurement noise. writing initial_estimate also loads the value estimate.
// an updating item runs from accept to out_valid as follows: a single
// saturating multiply/add unit runs 33 steps, each an issue and a wait state,
// a restoring divider forms the gain reciprocal and the output state loads
// the result. a zero innovation denominator skips the divider; a skipped
// item goes from accept straight to the output state.
// a new item is taken in the cycle after the previous result is loaded, so
// the block takes no new item before it is through with the last one.
// a finished result waits in the output register while out_stall is high; the
// next item is computed meanwhile and then holds until the register empties.
// reset loads the register reset values and clears all filter state.
`default_nettype none
module kalman_angle_bias_filter_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire kabf_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output kabf_pkg::out_item_t       out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import kabf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_ISSUE = 3'd1, S_WAIT = 3'd2,
                         S_DIV = 3'd3, S_OUT = 3'd4;

  // register file slots
  localparam logic [3:0] X_VE = 4'd0, X_BS = 4'd1, X_PE = 4'd2, X_VS = 4'd3,
    X_RS = 4'd4, X_P0 = 4'd5, X_P1 = 4'd6, X_P2 = 4'd7, X_P3 = 4'd8,
    X_T = 4'd9, X_U = 4'd10, X_K0 = 4'd11, X_K1 = 4'd12, X_IN = 4'd13,
    X_A = 4'd14, X_B = 4'd15;
  // constant operands
  localparam logic [3:0] C_DT = 4'd0, C_QV = 4'd1, C_QB = 4'd2, C_R = 4'd3,
    C_MV = 4'd4, C_MR = 4'd5, C_RC = 4'd6;

  typedef struct packed {
    logic [1:0] op;
    logic       ca;
    logic [3:0] a;
    logic       cb;
    logic [3:0] b;
    logic [3:0] dst;
  } step_t;

  localparam int NSTEP = 22;

  function automatic step_t prog(input logic [4:0] i);
    step_t s;
    s = '0;
    unique case (i)
      5'd0:  s = '{OP_SUB, 1'b0, X_VE, 1'b0, X_PE, X_VS};
      5'd1:  s = '{OP_ADD, 1'b0, X_VE, 1'b1, C_RC, X_PE}; // copy via + 0 (rc cleared)
      5'd2:  s = '{OP_SUB, 1'b1, C_MR, 1'b0, X_BS, X_RS};
      5'd3:  s = '{OP_MUL, 1'b1, C_DT, 1'b0, X_RS, X_T};
      5'd4:  s = '{OP_ADD, 1'b0, X_VE, 1'b0, X_T, X_VE};
      5'd5:  s = '{OP_MUL, 1'b1, C_DT, 1'b0, X_P3, X_U};
      5'd6:  s = '{OP_SUB, 1'b0, X_U, 1'b0, X_P1, X_T};
      5'd7:  s = '{OP_SUB, 1'b0, X_T, 1'b0, X_P2, X_T};
      5'd8:  s = '{OP_ADD, 1'b0, X_T, 1'b1, C_QV, X_T};
      5'd9:  s = '{OP_MUL, 1'b1, C_DT, 1'b0, X_T, X_T};
      5'd10: s = '{OP_ADD, 1'b0, X_P0, 1'b0, X_T, X_P0};
      5'd11: s = '{OP_SUB, 1'b0, X_P1, 1'b0, X_U, X_P1};
      5'd12: s = '{OP_SUB, 1'b0, X_P2, 1'b0, X_U, X_P2};
      5'd13: s = '{OP_MUL, 1'b1, C_QB, 1'b1, C_DT, X_T};
      5'd14: s = '{OP_ADD, 1'b0, X_P3, 1'b0, X_T, X_P3};
      5'd15: s = '{OP_ADD, 1'b0, X_P0, 1'b1, C_R, X_T};   // divider runs after this
      5'd16: s = '{OP_MUL, 1'b0, X_P0, 1'b1, C_RC, X_K0};
      5'd17: s = '{OP_MUL, 1'b0, X_P2, 1'b1, C_RC, X_K1};
      5'd18: s = '{OP_SUB, 1'b1, C_MV, 1'b0, X_VE, X_IN};
      5'd19: s = '{OP_MUL, 1'b0, X_K0, 1'b0, X_IN, X_T};
      5'd20: s = '{OP_ADD, 1'b0, X_VE, 1'b0, X_T, X_VE};
      5'd21: s = '{OP_MUL, 1'b0, X_K1, 1'b0, X_IN, X_T};
      default: s = '0;
    endcase
    return s;
  endfunction
  // covariance correction tail uses scratch slots A and B for saved p00 and p01
  function automatic step_t tail(input logic [3:0] i);
    step_t s;
    unique case (i)
      4'd0: s = '{OP_ADD, 1'b0, X_BS, 1'b0, X_T, X_BS};
      4'd1: s = '{OP_ADD, 1'b0, X_P0, 1'b1, C_RC, X_A};
      4'd2: s = '{OP_ADD, 1'b0, X_P1, 1'b1, C_RC, X_B};
      4'd3: s = '{OP_MUL, 1'b0, X_K0, 1'b0, X_A, X_T};
      4'd4: s = '{OP_SUB, 1'b0, X_P0, 1'b0, X_T, X_P0};
      4'd5: s = '{OP_MUL, 1'b0, X_K0, 1'b0, X_B, X_T};
      4'd6: s = '{OP_SUB, 1'b0, X_P1, 1'b0, X_T, X_P1};
      4'd7: s = '{OP_MUL, 1'b0, X_K1, 1'b0, X_A, X_T};
      4'd8: s = '{OP_SUB, 1'b0, X_P2, 1'b0, X_T, X_P2};
      4'd9: s = '{OP_MUL, 1'b0, X_K1, 1'b0, X_B, X_T};
      default: s = '{OP_SUB, 1'b0, X_P3, 1'b0, X_T, X_P3};
    endcase
    return s;
  endfunction

  logic [DW-1:0] init_r, life_r, qv_r, qb_r, rr_r;
  logic signed [DW-1:0] rf_r [16];
  in_item_t      item_r;
  logic signed [DW-1:0] rc_r;
  logic          zero_rc_r;
  logic [2:0]    state_r;
  logic [4:0]    pc_r;
  logic          tl_r;
  logic [6:0]    dcnt_r;
  logic [2*DW-1:0] rem_r, quo_r;
  logic [DW-1:0] dmag_r;
  logic          dneg_r;
  out_item_t     out_r;
  logic          ov_r;

  step_t st;
  logic [1:0] aop;
  logic signed [DW-1:0] opa, opb, ares;
  logic [2*DW:0] trial;
  logic wr;

  function automatic logic signed [DW-1:0] cval(input logic [3:0] c,
      input in_item_t it, input logic signed [DW-1:0] rc, input logic zr,
      input logic [DW-1:0] qv, input logic [DW-1:0] qb, input logic [DW-1:0] r);
    logic signed [DW-1:0] v;
    unique case (c)
      C_DT: v = sat_u(it.elapsed_time);
      C_QV: v = sat_u(qv);
      C_QB: v = sat_u(qb);
      C_R:  v = sat_u(r);
      C_MV: v = it.measured_value;
      C_MR: v = it.measured_rate;
      default: v = zr ? '0 : rc;
    endcase
    return v;
  endfunction

  always_comb begin
    st  = tl_r ? tail(pc_r[3:0]) : prog(pc_r);
    opa = st.ca ? cval(st.a, item_r, rc_r, zero_rc_r, qv_r, qb_r, rr_r) : rf_r[st.a];
    opb = st.cb ? cval(st.b, item_r, rc_r, zero_rc_r, qv_r, qb_r, rr_r) : rf_r[st.b];
    aop = st.op;
  end

  kabf_alu u_alu (.clk(clk), .op(aop), .a(opa), .b(opb), .res_r(ares));

  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[4:2])
      REG_INIT: prdata = init_r;
      REG_LIFE: prdata = life_r;
      REG_QV:   prdata = qv_r;
      REG_QB:   prdata = qb_r;
      REG_R:    prdata = rr_r;
      default:  prdata = '0;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;
  assign trial = {1'b0, rem_r} - {{(DW+1){1'b0}}, dmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0; life_r <= 32'd65536; qv_r <= 32'd66; qb_r <= 32'd197;
      rr_r <= 32'd1966;
      for (int i = 0; i < 16; i++) rf_r[i] <= '0;
      state_r <= S_IDLE; ov_r <= 1'b0; pc_r <= '0; tl_r <= 1'b0;
      zero_rc_r <= 1'b1; dcnt_r <= '0;
    end else begin
      if (wr) begin
        unique case (paddr[4:2])
          REG_INIT: begin init_r <= pwdata; rf_r[X_VE] <= pwdata; end
          REG_LIFE: life_r <= pwdata;
          REG_QV:   qv_r <= pwdata;
          REG_QB:   qb_r <= pwdata;
          REG_R:    rr_r <= pwdata;
          default: ;
        endcase
      end
      if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && !in_stall) begin
          item_r <= in_data;
          pc_r <= '0; tl_r <= 1'b0; zero_rc_r <= 1'b1;
          if (in_data.elapsed_time > life_r) state_r <= S_OUT;
          else state_r <= S_ISSUE;
        end
        S_ISSUE: state_r <= S_WAIT;
        S_WAIT: begin
          rf_r[st.dst] <= ares;
          if (!tl_r && pc_r == 5'd15) begin
            zero_rc_r <= 1'b0;
            if (ares == '0) begin
              rc_r <= SMAX; pc_r <= pc_r + 5'd1; state_r <= S_ISSUE;
            end else begin
              dmag_r <= ares[DW-1] ? DW'(-ares) : ares;
              dneg_r <= ares[DW-1];
              rem_r <= '0; quo_r <= (2*DW)'(1) << (2*FB);
              dcnt_r <= '0; state_r <= S_DIV;
            end
          end else if (!tl_r && pc_r == 5'(NSTEP-1)) begin
            tl_r <= 1'b1; pc_r <= '0; zero_rc_r <= 1'b1; state_r <= S_ISSUE;
          end else if (tl_r && pc_r == 5'd10) begin
            state_r <= S_OUT;
          end else begin
            pc_r <= pc_r + 5'd1; state_r <= S_ISSUE;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle; the compare runs
          // before the shift into the remainder.
          if (trial[2*DW]) begin
            rem_r <= {rem_r[2*DW-2:0], quo_r[2*DW-1]};
            quo_r <= {quo_r[2*DW-2:0], 1'b0};
          end else begin
            rem_r <= {trial[2*DW-2:0], quo_r[2*DW-1]};
            quo_r <= {quo_r[2*DW-2:0], 1'b1};
          end
          dcnt_r <= dcnt_r + 7'd1;
          if (dcnt_r == 7'(2*DW+1)) begin
            if (quo_r[2*DW-1:DW-1] != '0) rc_r <= dneg_r ? SMIN : SMAX;
            else rc_r <= dneg_r ? DW'(-quo_r[DW-1:0]) : quo_r[DW-1:0];
            pc_r <= pc_r + 5'd1; state_r <= S_ISSUE;
          end
        end
        S_OUT: if (!ov_r) begin
          out_r.estimate       <= rf_r[X_VE];
          out_r.bias_estimate  <= rf_r[X_BS];
          out_r.corrected_rate <= rf_r[X_RS];
          out_r.step_velocity  <= rf_r[X_VS];
          out_r.skipped        <= (item_r.elapsed_time > life_r);
          ov_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/kabf_alu.sv
// shared saturating multiply and add/subtract unit, one registered result
`default_nettype none
module kabf_alu (
  input  wire logic                         clk,
  input  wire logic [1:0]                   op,
  input  wire logic signed [kabf_pkg::DW-1:0] a,
  input  wire logic signed [kabf_pkg::DW-1:0] b,
  output logic signed [kabf_pkg::DW-1:0]      res_r
);
  import kabf_pkg::*;

  logic [DW-1:0]   ma, mb;
  logic [2*DW-1:0] prod, rnd;
  logic [DW:0]     mag;
  logic            neg;
  logic signed [DW:0] s;
  logic signed [DW-1:0] res_nxt;

  always_comb begin
    ma   = a[DW-1] ? DW'(-a) : a;
    mb   = b[DW-1] ? DW'(-b) : b;
    neg  = a[DW-1] ^ b[DW-1];
    prod = ma * mb;
    rnd  = prod + ((2*DW)'(1) << (FB-1));
    s    = 'x;
    mag  = '0;
    res_nxt = '0;
    unique case (op)
      OP_MUL: begin
        if (rnd[2*DW-1:FB+DW] != '0) begin
          res_nxt = neg ? SMIN : SMAX;
        end else begin
          mag = rnd[FB+DW:FB];
          if (mag[DW] || (mag[DW-1] && !neg)) res_nxt = neg ? SMIN : SMAX;
          else if (neg && mag[DW-1]) res_nxt = SMIN;
          else res_nxt = neg ? DW'(-mag[DW-1:0]) : mag[DW-1:0];
        end
      end
      OP_ADD, OP_SUB: begin
        s = (op == OP_ADD) ? ({a[DW-1], a} + {b[DW-1], b}) : ({a[DW-1], a} - {b[DW-1], b});
        if (s[DW] != s[DW-1]) res_nxt = s[DW] ? SMIN : SMAX;
        else res_nxt = s[DW-1:0];
      end
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) res_r <= res_nxt;

endmodule
`default_nettype wire
